// File: hdl/kmst_pkg.sv
// Shared types and constants for the Kruskal minimum spanning tree block.
// No dependencies; imported by every module in hdl/.
package kmst_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_EDGES    = 1024;
  localparam int VW           = $clog2(MAX_VERTICES);
  localparam int EW           = $clog2(MAX_EDGES);
  localparam int CW           = EW + 1;
  localparam int WW           = 32;
  localparam int NW           = VW + 1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DISCONN  = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [NW-1:0] VERTEX_COUNT_RESET = NW'(64);

  typedef struct packed {
    logic [VW-1:0]        from_v;
    logic [VW-1:0]        to_v;
    logic signed [WW-1:0] weight;
  } edge_t;

  typedef struct packed {
    logic          find;
    logic [VW-1:0] vertex;
    logic          wr;
    logic [VW-1:0] wr_addr;
    logic [VW-1:0] wr_data;
  } uf_req_t;

  typedef struct packed {
    logic          done;
    logic [VW-1:0] root;
  } uf_rsp_t;

endpackage

// File: hdl/kmst_edge_ram.sv
// Edge store: one write port, one registered read port.
// Depends on kmst_pkg.
module kmst_edge_ram import kmst_pkg::*; (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [EW-1:0] wr_addr,
  input  edge_t         wr_data,
  input  logic [EW-1:0] rd_addr,
  output edge_t         rd_data
);

  edge_t mem [MAX_EDGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: hdl/kmst_uf.sv
// Union-find parent store with a root walker, one parent hop per cycle.
// Depends on kmst_pkg.
module kmst_uf import kmst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  uf_req_t req,
  output uf_rsp_t rsp
);

  logic [VW-1:0] mem [MAX_VERTICES];
  logic [VW-1:0] rd_data;
  logic [VW-1:0] rd_addr;
  logic [VW-1:0] cur;
  logic          busy;
  logic          at_root;

  assign at_root = (rd_data == cur);
  assign rsp.done = busy && at_root;
  assign rsp.root = cur;

  // follow the link that just came back unless the walk starts over
  always_comb begin
    if (req.find) begin
      rd_addr = req.vertex;
    end else if (busy && !at_root) begin
      rd_addr = rd_data;
    end else begin
      rd_addr = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cur  <= '0;
    end else if (req.find) begin
      busy <= 1'b1;
      cur  <= req.vertex;
    end else if (busy) begin
      if (at_root) begin
        busy <= 1'b0;
      end else begin
        cur <= rd_data;
      end
    end
  end

endmodule

// File: hdl/kruskal_minimum_spanning_tree.sv
// Kruskal minimum spanning tree: edge loader, selection scan and union-find.
// Sequence: edges are taken while idle; after the last edge, a parent clearing pass
// over every vertex slot, then per examined edge one scan over the store plus
// two root walks; results wait on out_stall.
// Throughput: one edge per cycle while loading; no input is taken during a run.
// Reset: synchronous on rst; clears the edge count, overflow flag and vertex_count=64.
module kruskal_minimum_spanning_tree import kmst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // edge input transaction
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [VW-1:0]        from_vertex,
  input  logic [VW-1:0]        to_vertex,
  input  logic signed [WW-1:0] edge_weight,
  input  logic                 last_edge,
  // result transaction
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VW-1:0]        tree_low_vertex,
  output logic [VW-1:0]        tree_high_vertex,
  output logic signed [WW-1:0] tree_weight,
  output logic                 edge_valid,
  output logic [1:0]           status,
  output logic                 last_result,
  // configuration port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FINDA = 3'd3;
  localparam logic [2:0] S_FINDB = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;

  logic [2:0]    state;
  logic [NW-1:0] vertex_count;
  logic [NW-1:0] eff_n;
  logic [NW-1:0] target;
  logic [CW-1:0] edges_loaded;
  logic          overflow_seen;
  logic [NW-1:0] tree_found;

  // selection scan state
  logic [CW-1:0]        scan_idx;
  logic                 pv;
  logic [EW-1:0]        pv_idx;
  logic                 found;
  logic [EW-1:0]        best_idx;
  edge_t                best;
  logic                 have_prev;
  logic [EW-1:0]        prev_idx;
  logic signed [WW-1:0] prev_w;
  logic [VW-1:0]        clr_idx;
  logic [VW-1:0]        root_a;

  // pending result
  logic [VW-1:0]        pend_lo;
  logic [VW-1:0]        pend_hi;
  logic signed [WW-1:0] pend_w;
  logic                 pend_ev;
  logic [1:0]           pend_st;
  logic                 pend_last;

  edge_t   ram_wdata;
  edge_t   ram_rdata;
  logic    ram_we;
  logic    edge_ok;
  logic    in_fire;
  logic    cfg_wr;
  logic    beyond_prev;
  logic    take;
  logic    out_free;
  logic    scan_done;
  uf_req_t uf_req;
  uf_rsp_t uf_rsp;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_VERTEX_COUNT) ? {{(32-NW){1'b0}}, vertex_count} : '0;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_VERTEX_COUNT);

  // saturate the vertex count to the store's vertex range
  assign eff_n = (vertex_count > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vertex_count;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign edge_ok  = (from_vertex != to_vertex) && ({1'b0, from_vertex} < eff_n)
                    && ({1'b0, to_vertex} < eff_n);
  assign ram_we   = in_fire && edge_ok && (edges_loaded < CW'(MAX_EDGES));

  assign ram_wdata.from_v = from_vertex;
  assign ram_wdata.to_v   = to_vertex;
  assign ram_wdata.weight = edge_weight;

  kmst_edge_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (edges_loaded[EW-1:0]),
    .wr_data (ram_wdata),
    .rd_addr (scan_idx[EW-1:0]),
    .rd_data (ram_rdata)
  );

  // an edge is a candidate only if it sorts after the last one examined,
  // ordered by weight and then by arrival index
  assign beyond_prev = !have_prev || (ram_rdata.weight > prev_w)
                       || ((ram_rdata.weight == prev_w) && (pv_idx > prev_idx));
  // strict compare keeps the earliest edge on equal weights
  assign take      = pv && beyond_prev && (!found || (ram_rdata.weight < best.weight));
  assign scan_done = (scan_idx == edges_loaded) && !pv;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    uf_req = '0;
    unique case (state)
      S_CLEAR: begin
        uf_req.wr      = 1'b1;
        uf_req.wr_addr = clr_idx;
        uf_req.wr_data = clr_idx;
      end
      S_SCAN: begin
        uf_req.find   = scan_done && found;
        uf_req.vertex = best.from_v;
      end
      S_FINDA: begin
        uf_req.find   = uf_rsp.done;
        uf_req.vertex = best.to_v;
      end
      S_FINDB: begin
        // link the from root under the to root
        uf_req.wr      = uf_rsp.done && (uf_rsp.root != root_a);
        uf_req.wr_addr = root_a;
        uf_req.wr_data = uf_rsp.root;
      end
      default: begin
        uf_req = '0;
      end
    endcase
  end

  kmst_uf u_uf (
    .clk (clk),
    .rst (rst),
    .req (uf_req),
    .rsp (uf_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      vertex_count  <= VERTEX_COUNT_RESET;
      edges_loaded  <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
      tree_found    <= '0;
      pv            <= 1'b0;
      found         <= 1'b0;
      have_prev     <= 1'b0;
    end else begin
      if (cfg_wr) begin
        vertex_count <= pwdata[NW-1:0];
      end
      // drop an accepted result unless the emit step reloads the register
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            if (ram_we) begin
              edges_loaded <= edges_loaded + CW'(1);
            end else if (edge_ok) begin
              overflow_seen <= 1'b1;
            end
            if (last_edge) begin
              target     <= (eff_n != '0) ? eff_n - NW'(1) : '0;
              tree_found <= '0;
              have_prev  <= 1'b0;
              clr_idx    <= '0;
              state      <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + VW'(1);
          if (clr_idx == VW'(MAX_VERTICES - 1)) begin
            scan_idx <= '0;
            pv       <= 1'b0;
            found    <= 1'b0;
            if (target == '0) begin
              // nothing to connect: bare status only
              pend_lo   <= '0;
              pend_hi   <= '0;
              pend_w    <= '0;
              pend_ev   <= 1'b0;
              pend_st   <= overflow_seen ? STATUS_OVERFLOW : STATUS_OK;
              pend_last <= 1'b1;
              state     <= S_EMIT;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_idx != edges_loaded) begin
            pv       <= 1'b1;
            pv_idx   <= scan_idx[EW-1:0];
            scan_idx <= scan_idx + CW'(1);
          end else begin
            pv <= 1'b0;
          end
          if (take) begin
            found    <= 1'b1;
            best     <= ram_rdata;
            best_idx <= pv_idx;
          end
          if (scan_done) begin
            if (found) begin
              have_prev <= 1'b1;
              prev_w    <= best.weight;
              prev_idx  <= best_idx;
              state     <= S_FINDA;
            end else begin
              // edges ran out before the tree closed
              pend_lo   <= '0;
              pend_hi   <= '0;
              pend_w    <= '0;
              pend_ev   <= 1'b0;
              pend_st   <= overflow_seen ? STATUS_OVERFLOW : STATUS_DISCONN;
              pend_last <= 1'b1;
              state     <= S_EMIT;
            end
          end
        end
        S_FINDA: begin
          if (uf_rsp.done) begin
            root_a <= uf_rsp.root;
            state  <= S_FINDB;
          end
        end
        S_FINDB: begin
          if (uf_rsp.done) begin
            scan_idx <= '0;
            pv       <= 1'b0;
            found    <= 1'b0;
            if (uf_rsp.root == root_a) begin
              // cycle: drop the edge and look for the next one
              state <= S_SCAN;
            end else begin
              tree_found <= tree_found + NW'(1);
              pend_lo    <= (best.from_v < best.to_v) ? best.from_v : best.to_v;
              pend_hi    <= (best.from_v < best.to_v) ? best.to_v : best.from_v;
              pend_w     <= best.weight;
              pend_ev    <= 1'b1;
              pend_st    <= overflow_seen ? STATUS_OVERFLOW : STATUS_OK;
              pend_last  <= ((tree_found + NW'(1)) == target);
              state      <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            tree_low_vertex  <= pend_lo;
            tree_high_vertex <= pend_hi;
            tree_weight      <= pend_w;
            edge_valid       <= pend_ev;
            status           <= pend_st;
            last_result      <= pend_last;
            if (pend_last) begin
              // run finished: empty the store for the next graph
              edges_loaded  <= '0;
              overflow_seen <= 1'b0;
              state         <= S_IDLE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/kmst_checker.sv
// Port-level checks for the spanning tree block, bound to the top level.
// Depends on kmst_pkg.
module kmst_checker import kmst_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input logic [VW-1:0] tree_low_vertex,
  input logic [VW-1:0] tree_high_vertex,
  input logic          edge_valid,
  input logic [1:0]    status,
  input logic          last_result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tree_low_vertex))
    else $error("result dropped under stall");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && edge_valid |-> tree_low_vertex < tree_high_vertex)
    else $error("tree edge endpoints out of order");

  a_bare: assert property (@(posedge clk) disable iff (rst)
    out_valid && !edge_valid |-> last_result && tree_low_vertex == '0)
    else $error("bare status not final");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STATUS_OK || status == STATUS_DISCONN
                  || status == STATUS_OVERFLOW)
    else $error("bad status code");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> in_stall)
    else $error("input taken during a run");

endmodule

bind kruskal_minimum_spanning_tree kmst_checker u_kmst_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .tree_low_vertex  (tree_low_vertex),
  .tree_high_vertex (tree_high_vertex),
  .edge_valid       (edge_valid),
  .status           (status),
  .last_result      (last_result)
);
